// File: hw/rtl/sorted_key_index_table_top_assert.svh
// assertion macros for the sorted key index table
`ifndef SORTED_KEY_INDEX_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_INDEX_TABLE_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define SKTI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skti assertion failed");

// next-cycle implication, off during reset
`define SKTI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skti assertion failed");

`endif

// File: hw/rtl/skti_pkg.sv
// types, codes and constants of the sorted key index table
package skti_pkg;

    localparam int KEY_W             = 32;
    localparam int REC_W             = 5;
    localparam int STATUS_W          = 2;
    localparam int TABLE_DEPTH_DEF   = 32;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DUMP   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic [REC_W-1:0]        record_number;
        logic [STATUS_W-1:0]     status;
        logic                    last;
    } rsp_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [REC_W-1:0]        rec;
    } entry_t;

    typedef struct packed {
        logic   ins;
        logic   rot;
        entry_t fresh;
    } cell_ctrl_t;

    typedef struct packed {
        logic occ;
        logic greater;
    } link_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

endpackage

// File: hw/rtl/sorted_key_index_table_top.sv
// sorted key index table: top level with control, result register and the cell chain
//
// Keeps up to TABLE_DEPTH entries sorted by ascending signed key in a chain of
// compare-and-shift cells. An insert's result beat comes out on the cycle after
// start is taken, and busy stays low, so inserts can be issued every cycle. A dump
// of the stored entries raises busy while the chain rotates one slot per cycle past
// its head cell, giving one beat per cycle in key order; an empty dump gives a
// single beat flagged empty without raising busy. Results are strobed by done for
// exactly one cycle and cannot be held off. An insert into a full table is dropped
// and flagged in its beat.
module sorted_key_index_table_top #(
    parameter int TABLE_DEPTH = skti_pkg::TABLE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  skti_pkg::req_t req,
    output logic           done,
    output skti_pkg::rsp_t rsp
);
    import skti_pkg::*;

    `include "sorted_key_index_table_top_assert.svh"

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             done_reg, done_next;
    rsp_t             rsp_reg, rsp_next;

    cell_ctrl_t             ctrl;
    entry_t                 cell_q [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] greater;
    logic [TABLE_DEPTH-1:0] occ;
    logic [TABLE_DEPTH-1:0] wrap;

    logic accept;
    logic full;
    logic dump_last;

    assign busy      = (state_reg == ST_DUMP);
    assign accept    = start && !busy;
    assign full      = (count_reg >= DEPTH_C);
    assign dump_last = (idx_reg == count_reg - CNT_W'(1));
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            occ[i]  = (CNT_W'(i) < count_reg);
            wrap[i] = (CNT_W'(i + 1) == count_reg);
        end
    end

    always_comb
    begin
        ctrl.ins       = accept && (req.mode == MODE_INSERT) && !full;
        ctrl.rot       = busy;
        ctrl.fresh.key = req.key;
        ctrl.fresh.rec = REC_W'(count_reg);
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : gen_cell
        link_t  below_link;
        entry_t below_entry;
        entry_t above_entry;

        if (g == 0)
        begin : gen_bottom
            assign below_link.occ     = 1'b1;
            assign below_link.greater = 1'b0;
            assign below_entry        = cell_q[0];
        end
        else
        begin : gen_inner
            assign below_link.occ     = occ[g-1];
            assign below_link.greater = greater[g-1];
            assign below_entry        = cell_q[g-1];
        end

        if (g == TABLE_DEPTH - 1)
        begin : gen_top
            assign above_entry = cell_q[0];
        end
        else
        begin : gen_mid
            assign above_entry = cell_q[g+1];
        end

        skti_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occ        (occ[g]),
            .wrap       (wrap[g]),
            .below_link (below_link),
            .below      (below_entry),
            .above      (above_entry),
            .head       (cell_q[0]),
            .entry      (cell_q[g]),
            .greater    (greater[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode == MODE_INSERT)
                    begin
                        done_next          = 1'b1;
                        rsp_next.out_key   = req.key;
                        rsp_next.last      = 1'b1;
                        if (full)
                        begin
                            rsp_next.record_number = '0;
                            rsp_next.status        = STATUS_FULL;
                        end
                        else
                        begin
                            rsp_next.record_number = REC_W'(count_reg);
                            rsp_next.status        = STATUS_OK;
                            count_next             = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next              = 1'b1;
                        rsp_next.out_key       = '0;
                        rsp_next.record_number = '0;
                        rsp_next.status        = STATUS_EMPTY;
                        rsp_next.last          = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DUMP;
                        idx_next   = '0;
                    end
                end
            end
            ST_DUMP:
            begin
                done_next              = 1'b1;
                rsp_next.out_key       = cell_q[0].key;
                rsp_next.record_number = cell_q[0].rec;
                rsp_next.status        = STATUS_OK;
                rsp_next.last          = dump_last;
                idx_next               = idx_reg + CNT_W'(1);
                if (dump_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    `SKTI_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= DEPTH_C)
    `SKTI_ASSERT_NOW(a_dump_idx, busy, idx_reg < count_reg)
    `SKTI_ASSERT_NEXT(a_insert_count, ctrl.ins, count_reg == $past(count_reg) + CNT_W'(1))
    `SKTI_ASSERT_NEXT(a_dump_end, busy && dump_last,
        !busy && done_reg && rsp_reg.last)

endmodule

// File: hw/rtl/skti_cell.sv
// one table slot: compare against the new key, shift up on insert, rotate down on dump
module skti_cell (
    input  logic                clk,
    input  skti_pkg::cell_ctrl_t ctrl,
    input  logic                occ,
    input  logic                wrap,
    input  skti_pkg::link_t     below_link,
    input  skti_pkg::entry_t    below,
    input  skti_pkg::entry_t    above,
    input  skti_pkg::entry_t    head,
    output skti_pkg::entry_t    entry,
    output logic                greater
);
    import skti_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    assign greater = occ && (entry_reg.key > ctrl.fresh.key);
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (below_link.greater)
            begin
                entry_next = below;
            end
            else if (greater || (!occ && below_link.occ))
            begin
                entry_next = ctrl.fresh;
            end
        end
        else if (ctrl.rot && occ)
        begin
            entry_next = wrap ? head : above;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: sim/sorted_key_index_table_top_tb.sv
// testbench for the sorted key index table: directed and random beats against a sorted shadow copy
module sorted_key_index_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skti_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = DEPTH + 8;
    localparam int MAX_PRINTED = 40;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    entry_t shadow_entries[$];
    rsp_t   rsp_due[$];

    int          errors;
    int          sender_idle_pct;
    int          n_inserts;
    int          n_dropped;
    int          n_dumps;
    int          n_beats;
    int unsigned stall_cycles;

    sorted_key_index_table_top #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    always #6ns clk = ~clk;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED)
        begin
            $display("mismatch @%0t: %s", $realtime, msg);
        end
    endtask

    // expected beats of one request, applied to the shadow copy
    function automatic void predict_response(input req_t item);
        entry_t fresh;
        rsp_t   beat;
        int     slot;
        if (item.mode == MODE_INSERT)
        begin
            if (shadow_entries.size() >= DEPTH)
            begin
                beat = '{out_key: item.key, record_number: '0, status: STATUS_FULL, last: 1'b1};
                n_dropped++;
            end
            else
            begin
                fresh.key = item.key;
                fresh.rec = REC_W'(shadow_entries.size());
                slot = shadow_entries.size();
                while (slot > 0 && shadow_entries[slot-1].key > item.key)
                begin
                    slot--;
                end
                shadow_entries.insert(slot, fresh);
                beat = '{out_key: item.key, record_number: fresh.rec,
                         status: STATUS_OK, last: 1'b1};
            end
            rsp_due.push_back(beat);
        end
        else if (shadow_entries.size() == 0)
        begin
            beat = '{out_key: '0, record_number: '0, status: STATUS_EMPTY, last: 1'b1};
            rsp_due.push_back(beat);
        end
        else
        begin
            foreach (shadow_entries[i])
            begin
                beat.out_key       = shadow_entries[i].key;
                beat.record_number = shadow_entries[i].rec;
                beat.status        = STATUS_OK;
                beat.last          = (i == shadow_entries.size() - 1);
                rsp_due.push_back(beat);
            end
        end
    endfunction

    function automatic req_t mk_insert(input logic signed [KEY_W-1:0] k);
        req_t item;
        item.mode = MODE_INSERT;
        item.key  = k;
        return item;
    endfunction

    // key field is random, the block must ignore it
    function automatic req_t mk_dump();
        req_t item;
        item.mode = MODE_DUMP;
        item.key  = $urandom;
        return item;
    endfunction

    function automatic logic signed [KEY_W-1:0] rand_key();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return KEY_MIN + $urandom_range(0, 3);
            1: return KEY_MAX - $urandom_range(0, 3);
            2, 3: return int'($urandom_range(0, 8)) - 4;
            4:
            begin
                if (shadow_entries.size() > 0)
                begin
                    return shadow_entries[$urandom_range(0, shadow_entries.size() - 1)].key;
                end
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        req   <= req_t'({$urandom, $urandom});
        repeat (n) @(posedge clk);
    endtask

    // drives one beat and holds it until taken
    task automatic send_item(input req_t item);
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        predict_response(item);
        if (item.mode == MODE_DUMP)
        begin
            n_dumps++;
        end
        else
        begin
            n_inserts++;
        end
    endtask

    task automatic issue(input req_t item);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            idle_cycles($urandom_range(1, 8));
        end
        send_item(item);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (rsp_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic test_empty_dump();
        sender_idle_pct = 0;
        issue(mk_dump());
        issue(mk_dump());
    endtask

    task automatic test_key_extremes();
        sender_idle_pct = 0;
        issue(mk_insert(0));
        issue(mk_insert(KEY_MAX));
        issue(mk_insert(KEY_MIN));
        issue(mk_insert(-1));
        issue(mk_insert(1));
        issue(mk_dump());
        issue(mk_insert(KEY_MAX));
        issue(mk_insert(KEY_MIN));
        issue(mk_insert(0));
        issue(mk_insert(32'sh5555_aaaa));
        issue(mk_insert(32'sh2aaa_5555));
        issue(mk_dump());
        issue(mk_dump());
        issue(mk_insert(-5));
    endtask

    task automatic test_full_table();
        sender_idle_pct = 0;
        while (shadow_entries.size() < DEPTH)
        begin
            issue(mk_insert(rand_key()));
        end
        issue(mk_dump());
        issue(mk_insert(KEY_MIN));
        issue(mk_insert(KEY_MAX));
        issue(mk_dump());
        issue(mk_insert(0));
    endtask

    task automatic test_random_phase(input int n_items, input int pct_idle, input int pct_dump);
        sender_idle_pct = pct_idle;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 99) < pct_dump)
            begin
                issue(mk_dump());
            end
            else
            begin
                issue(mk_insert(rand_key()));
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        rsp_t expd;
        if (rst_n && done)
        begin
            n_beats++;
            if (rsp_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat key %0d rec %0d status %0d last %0b",
                                          rsp.out_key, rsp.record_number, rsp.status, rsp.last));
            end
            else
            begin
                expd = rsp_due.pop_front();
                if (rsp.out_key !== expd.out_key)
                    report_mismatch($sformatf("beat %0d out_key %0d, expected %0d",
                                              n_beats, rsp.out_key, expd.out_key));
                if (rsp.record_number !== expd.record_number)
                    report_mismatch($sformatf("beat %0d record_number %0d, expected %0d",
                                              n_beats, rsp.record_number, expd.record_number));
                if (rsp.status !== expd.status)
                    report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                              n_beats, rsp.status, expd.status));
                if (rsp.last !== expd.last)
                    report_mismatch($sformatf("beat %0d last %0b, expected %0b",
                                              n_beats, rsp.last, expd.last));
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d still expected",
                     STALL_LIMIT, rsp_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_dump();
        test_key_extremes();
        wait_drained();
        test_random_phase(60, 0, 15);
        test_full_table();
        wait_drained();
        test_random_phase(120, 0, 30);
        wait_drained();
        test_random_phase(120, 62, 30);
        wait_drained();
        test_random_phase(100, 26, 30);
        wait_drained();

        $display("checked %0d beats from %0d inserts (%0d dropped on a full table) and %0d dumps",
                 n_beats, n_inserts, n_dropped, n_dumps);
        $display("covered empty and full table, extreme and repeated keys, sender gaps; %0d errors",
                 errors + rsp_due.size());
        if (errors == 0 && rsp_due.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/skti_pkg.sv
hw/rtl/skti_cell.sv
hw/rtl/sorted_key_index_table_top.sv
sim/sorted_key_index_table_top_tb.sv
